// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checksum RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/tuc_pkg.sv =====
// Types and constants for the TCP/UDP checksum block.
// No dependencies; used by all checksum modules.
package tuc_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ADDRESS      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DESTINATION_ADDRESS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_NUMBER     = 2'd2;

	localparam logic [7:0] PROTOCOL_RESET = 8'd6;

	typedef struct packed {
		logic [7:0] segment_byte;
		logic       final_byte;
	} in_word_t;

	typedef struct packed {
		logic [15:0] checksum_value;
		logic [15:0] segment_length;
	} out_word_t;

	// one completed 16-bit segment word, with length on the final one
	typedef struct packed {
		logic        valid;
		logic [15:0] word;
		logic        last;
		logic [15:0] len;
	} seg_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== sv/tuc_front.sv =====
// Front end: takes segment bytes, pairs them into big-endian words, counts length.
// Depends on tuc_pkg.
module tuc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tuc_pkg::in_word_t    in_data,
	input  tuc_pkg::queue_stat_t qstat,
	output tuc_pkg::seg_entry_t  push
);
	import tuc_pkg::*;

	logic        odd_q;
	logic [7:0]  high_q;
	logic [15:0] count_q;
	logic [15:0] count_next;
	logic        accept;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	// length saturates at all ones
	assign count_next = (count_q == 16'hffff) ? count_q : count_q + 16'd1;

	always_comb begin
		push.valid = accept && (odd_q || in_data.final_byte);
		push.last  = in_data.final_byte;
		push.len   = count_next;
		if (odd_q) begin
			push.word = {high_q, in_data.segment_byte};
		end else begin
			// odd leftover byte, low byte padded with zero
			push.word = {in_data.segment_byte, 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q   <= 1'b0;
			high_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (in_data.final_byte) begin
				odd_q   <= 1'b0;
				count_q <= '0;
			end else begin
				odd_q   <= !odd_q;
				count_q <= count_next;
			end
			if (!odd_q) begin
				high_q <= in_data.segment_byte;
			end
		end
	end

endmodule

// ===== sv/tuc_queue.sv =====
// Short register queue of segment words between front and back.
// Depends on tuc_pkg.
module tuc_queue #(
	parameter int DEPTH = tuc_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tuc_pkg::seg_entry_t  push,
	input  logic                 pop,
	output tuc_pkg::seg_entry_t  head,
	output tuc_pkg::queue_stat_t qstat
);
	import tuc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	seg_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);

	always_comb begin
		head       = mem_q[rd_ptr_q];
		head.valid = !qstat.empty;
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/tuc_back.sv =====
// Back end: ones' complement running sum, pseudo header and result register.
// Holds the configuration registers. Depends on tuc_pkg.
module tuc_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tuc_pkg::seg_entry_t                 head,
	output logic                                pop,
	input  logic                                cfg_we,
	input  logic [tuc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [31:0]                         cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tuc_pkg::out_word_t                  out_data
);
	import tuc_pkg::*;

	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [7:0]  proto_q;
	logic [15:0] ph_sum_q;
	logic [18:0] ph_raw;
	logic [16:0] ph_f1;

	logic [15:0] run_q;
	logic [16:0] run_raw;
	logic [16:0] run_f1;

	logic        s1_valid_q;
	logic [16:0] part_s1;
	logic [16:0] lenph_s1;
	logic [15:0] len_s1;
	logic [17:0] tot_raw;
	logic [16:0] tot_f1;
	logic [15:0] tot_f2;

	logic out_free;
	logic s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q   <= '0;
			dst_q   <= '0;
			proto_q <= PROTOCOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_ADDRESS:      src_q   <= cfg_data;
				REG_DESTINATION_ADDRESS: dst_q   <= cfg_data;
				REG_PROTOCOL_NUMBER:     proto_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// address and protocol words, folded twice into a registered sum
	assign ph_raw = 19'(src_q[31:16]) + 19'(src_q[15:0]) + 19'(dst_q[31:16])
		+ 19'(dst_q[15:0]) + 19'(proto_q);
	assign ph_f1  = 17'(ph_raw[15:0]) + 17'(ph_raw[18:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_sum_q <= 16'(PROTOCOL_RESET);
		end else begin
			ph_sum_q <= ph_f1[15:0] + 16'(ph_f1[16]);
		end
	end

	assign out_free = !out_valid || out_ready;
	assign s1_free  = !s1_valid_q || out_free;
	assign pop      = head.valid && s1_free;

	assign run_raw = 17'(run_q) + 17'(head.word);
	assign run_f1  = 17'(run_raw[15:0]) + 17'(run_raw[16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				run_q <= head.last ? 16'd0 : run_f1[15:0];
			end
			if (pop && head.last) begin
				s1_valid_q <= 1'b1;
			end else if (out_free) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			part_s1  <= run_raw;
			lenph_s1 <= 17'(head.len) + 17'(ph_sum_q);
			len_s1   <= head.len;
		end
	end

	// two folds bring the 18-bit total back to 16 bits
	assign tot_raw = 18'(part_s1) + 18'(lenph_s1);
	assign tot_f1  = 17'(tot_raw[15:0]) + 17'(tot_raw[17:16]);
	assign tot_f2  = tot_f1[15:0] + 16'(tot_f1[16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_valid_q && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && out_free) begin
			out_data.checksum_value <= ~tot_f2;
			out_data.segment_length <= len_s1;
		end
	end

endmodule

// ===== sv/tcp_udp_checksum_top.sv =====
// Top level of the TCP/UDP checksum with IPv4 pseudo header.
// Depends on tuc_pkg, tuc_front, tuc_queue, tuc_back, assert_macros.svh.
//
//   channel  signals                          word / use
//   in       in_valid in_ready in_data        one segment byte, final mark
//   out      out_valid out_ready out_data     checksum and segment length
//   cfg      cfg_we cfg_index cfg_data        register write, no wait
//
// One byte accepted per cycle while in_ready is high; the back end sums one
// 16-bit word per cycle while the sum stage is free. The final word is queued
// as the final byte is taken; the sum stage and the output register follow.
// in_ready drops only when the word queue is full; the queue fills while
// out_ready is held low and the back end holds the pending result.
// Reset clears all control state and sets protocol_number to 6.
`include "assert_macros.svh"
module tcp_udp_checksum_top #(
	parameter int QUEUE_DEPTH = tuc_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tuc_pkg::in_word_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tuc_pkg::out_word_t              out_data,
	input  logic                            cfg_we,
	input  logic [tuc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data
);
	import tuc_pkg::*;

	seg_entry_t  push;
	seg_entry_t  head;
	queue_stat_t qstat;
	logic        pop;
	logic        final_take;

	assign final_take = in_valid && in_ready && in_data.final_byte;

	tuc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.qstat    (qstat),
		.push     (push)
	);

	tuc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	tuc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`ASSERT_ALWAYS(a_queue_no_overflow, !(push.valid && qstat.full), "push into full queue")
	`ASSERT_IMPLY(a_final_pushes, final_take, push.valid, "final byte lost")
	`ASSERT_IMPLY(a_out_from_queue, $rose(out_valid), $past(!qstat.empty, 2), "result without word")

endmodule
